// ----- design/fixed_width_decimal_formatter_unit_macros.svh -----
`ifndef FIXED_WIDTH_DECIMAL_FORMATTER_UNIT_MACROS_SVH
`define FIXED_WIDTH_DECIMAL_FORMATTER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define FWDF_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define FWDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fwdf_pkg.sv -----
`timescale 1ns / 1ps

package fwdf_pkg;

  localparam int MAX_DIGITS = 16;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int DIG_W      = 4;
  localparam int VAL_W      = 32;
  localparam int CHAR_W     = 7;

  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
  localparam logic [VAL_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CHR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHR_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CHR_MINUS = 7'h2D;

  localparam logic [1:0] STYLE_ZERO = 2'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_SLOT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [DIG_W-1:0] digit;
  } buf_ctl_t;

  typedef struct packed {
    logic [DIG_W-1:0] d0;
    logic [DIG_W-1:0] d1;
  } buf_taps_t;

endpackage

// ----- design/fixed_width_decimal_formatter_unit.sv -----
`timescale 1ns / 1ps

// Fixed-width decimal formatter. Each request carries a 32-bit value, a digit
// count (0 reads as 1, above 16 reads as 16) and a style (0 zero padded,
// 1 space padded, 2 or 3 signed with one extra leading sign slot). The block
// answers with ASCII characters on the master stream, most significant first,
// tlast on the final one; only the low digit_count digits are kept. A
// negative value in signed style gets its minus just before the first kept
// digit. The request is taken first, then each digit passes through the
// shared divide-by-ten unit (reciprocal multiply, then remainder subtract),
// then the characters follow one per cycle while the output is not stalled.
// s_tready is high only while idle.
module fixed_width_decimal_formatter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] value, [36:32] digit_count, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] style
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] text_char, [7] zero
  output logic        m_tlast    // last_char
);
  import fwdf_pkg::*;
  `include "fixed_width_decimal_formatter_unit_macros.svh"

  state_t state, state_next;

  logic [VAL_W-1:0] mag;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rem_cnt;
  logic [CNT_W-1:0] idx;
  logic             is_signed;
  logic             pad_space;
  logic             negative;
  logic             seen;

  logic [CHAR_W-1:0] text_char;
  logic              last_char;

  // request fields
  logic [VAL_W-1:0] in_value;
  logic [4:0]       in_count;
  logic [1:0]       in_style;
  logic [CNT_W-1:0] in_count_sat;

  logic [VAL_W-1:0] div_quot;
  logic [DIG_W-1:0] div_rem;
  buf_ctl_t         buf_ctl;
  buf_taps_t        taps;

  logic              accept;
  logic              step;       // output register free this cycle
  logic              out_load;
  logic [CHAR_W-1:0] ch;
  logic              ch_last;
  logic              last_pos;
  logic              next_kept;

  assign in_value = s_tdata[31:0];
  assign in_count = s_tdata[36:32];
  assign in_style = s_tuser;

  always_comb begin
    if (in_count == 5'd0) begin
      in_count_sat = CNT_W'(1);
    end else if (32'(in_count) > 32'(MAX_DIGITS)) begin
      in_count_sat = CNT_W'(MAX_DIGITS);
    end else begin
      in_count_sat = CNT_W'(in_count);
    end
  end

  // no request is taken while reset is held
  assign s_tready = (state == ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign step     = !m_tvalid || m_tready;

  fwdf_div10 u_div (
    .clk      (clk),
    .load     (state == ST_MUL),
    .dividend (mag),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  fwdf_digit_buf u_buf (
    .clk  (clk),
    .ctl  (buf_ctl),
    .taps (taps)
  );

  // Readout: in the space-padded and signed styles, a leading zero (before any
  // kept digit, never the final one) becomes a space, or a minus when the next digit is the first kept one.
  assign last_pos  = (idx == CNT_W'(count - 1'b1));
  assign next_kept = (taps.d1 != '0) || (CNT_W'(idx + 1'b1) == CNT_W'(count - 1'b1));

  always_comb begin
    state_next    = state;
    buf_ctl.push  = 1'b0;
    buf_ctl.pop   = 1'b0;
    buf_ctl.digit = div_rem;
    out_load      = 1'b0;
    ch            = CHR_SPACE;
    ch_last       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_SUB;
      end
      ST_SUB: begin
        buf_ctl.push = 1'b1;
        if (rem_cnt == CNT_W'(1)) begin
          state_next = is_signed ? ST_SLOT : ST_EMIT;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_SLOT: begin
        // first kept digit is the head one when nonzero or the only one
        if (negative && ((taps.d0 != '0) || (count == CNT_W'(1)))) begin
          ch = CHR_MINUS;
        end
        if (step) begin
          out_load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pad_space && !seen && (taps.d0 == '0) && !last_pos) begin
          ch = (negative && next_kept) ? CHR_MINUS : CHR_SPACE;
        end else begin
          ch = CHR_ZERO + CHAR_W'(taps.d0);
        end
        ch_last = last_pos;
        if (step) begin
          out_load    = 1'b1;
          buf_ctl.pop = 1'b1;
          if (last_pos) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer data registers
  always_ff @(posedge clk) begin
    if (accept) begin
      is_signed <= in_style[1];
      pad_space <= (in_style != STYLE_ZERO);
      negative  <= in_style[1] && in_value[VAL_W-1];
      mag       <= (in_style[1] && in_value[VAL_W-1]) ? (VAL_W'(0) - in_value) : in_value;
      count     <= in_count_sat;
      rem_cnt   <= in_count_sat;
      idx       <= '0;
      seen      <= 1'b0;
    end else if (state == ST_SUB) begin
      mag     <= div_quot;
      rem_cnt <= rem_cnt - 1'b1;
    end else if (state == ST_EMIT && out_load) begin
      idx <= idx + 1'b1;
      if (taps.d0 != '0) begin
        seen <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      text_char <= ch;
      last_char <= ch_last;
    end
  end

  assign m_tdata = {1'b0, text_char};
  assign m_tlast = last_char;

  `FWDF_ASSERT_NEXT(a_accept_starts_div, accept, state == ST_MUL, "request did not start division")
  `FWDF_ASSERT(a_div_count_live, (state == ST_MUL) || (state == ST_SUB), rem_cnt != '0, "digit counter ran out during division")
  `FWDF_ASSERT(a_emit_in_range, state == ST_EMIT, idx < count, "readout index beyond digit count")
  `FWDF_ASSERT_NEXT(a_last_ends_item, (state == ST_EMIT) && out_load && last_pos, (state == ST_IDLE) && m_tvalid && m_tlast, "final character did not close the request")

endmodule

// ----- design/fwdf_div10.sv -----
`timescale 1ns / 1ps

// Divide by ten: reciprocal multiply into a register, then
// quotient extract and remainder subtract on the next cycle.
module fwdf_div10 (
  input  logic                       clk,
  input  logic                       load,
  input  logic [fwdf_pkg::VAL_W-1:0] dividend,
  output logic [fwdf_pkg::VAL_W-1:0] quot,
  output logic [fwdf_pkg::DIG_W-1:0] rem
);
  import fwdf_pkg::*;

  logic [2*VAL_W-1:0] prod;
  logic [VAL_W-1:0]   diff;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= (2*VAL_W)'(dividend) * (2*VAL_W)'(RECIP_TEN);
    end
  end

  assign quot = VAL_W'(prod >> RECIP_SHIFT);
  // x - 10q, always below ten
  assign diff = dividend - (quot << 3) - (quot << 1);
  assign rem  = diff[DIG_W-1:0];

endmodule

// ----- design/fwdf_digit_buf.sv -----
`timescale 1ns / 1ps

// Digit shift line. Push enters at the head and moves the rest back,
// so digits produced low first end with the most significant at the head.
// Pop moves everything toward the head for readout.
module fwdf_digit_buf (
  input  logic                clk,
  input  fwdf_pkg::buf_ctl_t  ctl,
  output fwdf_pkg::buf_taps_t taps
);
  import fwdf_pkg::*;

  logic [DIG_W-1:0] dig [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      dig[0] <= ctl.digit;
      for (int j = 1; j < MAX_DIGITS; j++) begin
        dig[j] <= dig[j-1];
      end
    end else if (ctl.pop) begin
      for (int j = 0; j < MAX_DIGITS - 1; j++) begin
        dig[j] <= dig[j+1];
      end
      dig[MAX_DIGITS-1] <= '0;
    end
  end

  assign taps.d0 = dig[0];
  assign taps.d1 = dig[1];

endmodule

// ----- verif/fixed_width_decimal_formatter_unit_tb.sv -----
`timescale 1ns / 1ps

module fixed_width_decimal_formatter_unit_tb;
  import fwdf_pkg::*;

  localparam logic [1:0] STYLE_SPACE      = 2'd1;
  localparam logic [1:0] STYLE_SIGNED     = 2'd2;
  localparam logic [1:0] STYLE_SIGNED_ALT = 2'd3;

  localparam int RANDOM_ITEMS = 430;
  localparam int STALL_LIMIT  = 4000;  // cycles with no handshake on either side
  localparam int TAIL_CYCLES  = 60;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } out_char_t;

  typedef struct {
    logic [31:0] value;
    logic [4:0]  count;
    logic [1:0]  style;
    string       text;   // empty: use the predictor
  } dir_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  logic        steady = 1'b0;  // no idling on either side while set
  int          errors = 0;
  int          quiet_cycles = 0;
  out_char_t   chars_due [$];

  // Directed: field extremes, every style, count clamping, cut-down values,
  // the most negative value and a negative value cut to all zeros.
  dir_row_t dir_rows [22] = '{
    '{32'd0,         5'd1,  STYLE_ZERO,       "0"},
    '{32'd0,         5'd0,  STYLE_ZERO,       "0"},
    '{32'hFFFF_FFFF, 5'd10, STYLE_ZERO,       "4294967295"},
    '{32'hFFFF_FFFF, 5'd31, STYLE_ZERO,       "0000004294967295"},
    '{32'hFFFF_FFFF, 5'd12, STYLE_SPACE,      "  4294967295"},
    '{32'd0,         5'd4,  STYLE_SPACE,      "   0"},
    '{32'd12345,     5'd3,  STYLE_ZERO,       "345"},
    '{32'd1005,      5'd3,  STYLE_SPACE,      "  5"},
    '{32'h8000_0000, 5'd10, STYLE_SIGNED,     "-2147483648"},
    '{32'h8000_0000, 5'd12, STYLE_SIGNED_ALT, "  -2147483648"},
    '{32'hFFFF_FFFF, 5'd1,  STYLE_SIGNED,     "-1"},
    '{32'hFFFF_FFFF, 5'd4,  STYLE_SIGNED,     "   -1"},
    '{32'hFFFF_FC18, 5'd3,  STYLE_SIGNED,     "  -0"},
    '{32'd1000,      5'd3,  STYLE_SIGNED,     "   0"},
    '{32'h7FFF_FFFF, 5'd10, STYLE_SIGNED,     " 2147483647"},
    '{32'd0,         5'd0,  STYLE_SIGNED_ALT, " 0"},
    '{32'd42,        5'd20, STYLE_ZERO,       ""},
    '{32'hAAAA_AAAA, 5'd16, STYLE_SIGNED_ALT, ""},
    '{32'h5555_5555, 5'd9,  STYLE_SPACE,      ""},
    '{32'd123456789, 5'd17, STYLE_SIGNED,     ""},
    '{32'h8000_0001, 5'd16, STYLE_SIGNED,     ""},
    '{32'd987654321, 5'd7,  STYLE_SPACE,      ""}
  };

  fixed_width_decimal_formatter_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Queue the characters one request should produce.
  function automatic void format_decimal(input logic [31:0] v, input logic [4:0] c,
                                         input logic [1:0] st);
    logic [CHAR_W-1:0] txt [MAX_DIGITS];
    logic [CHAR_W-1:0] slot;
    logic [31:0]       mag;
    logic              sgn;
    logic              neg;
    int                n;
    int                lead;
    n    = (c == 0) ? 1 : ((c > MAX_DIGITS) ? MAX_DIGITS : int'(c));
    sgn  = (st == STYLE_SIGNED) || (st == STYLE_SIGNED_ALT);
    neg  = sgn && v[31];
    mag  = neg ? (32'd0 - v) : v;
    lead = 0;
    for (int i = n - 1; i >= 0; i--) begin
      txt[i] = CHR_ZERO + CHAR_W'(mag % 10);
      mag    = mag / 10;
    end
    // blank leading zeros, final digit always stays
    if (st != STYLE_ZERO) begin
      while (lead + 1 < n && txt[lead] == CHR_ZERO) begin
        txt[lead] = CHR_SPACE;
        lead++;
      end
    end
    if (sgn) begin
      slot = CHR_SPACE;
      if (neg) begin
        if (lead == 0) slot = CHR_MINUS;
        else txt[lead-1] = CHR_MINUS;
      end
      chars_due.push_back({slot, 1'b0});
    end
    for (int i = 0; i < n; i++) chars_due.push_back({txt[i], i == n - 1});
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // One request; expectations are queued at the accepting edge.
  task automatic send_request(input logic [31:0] v, input logic [4:0] c,
                              input logic [1:0] st, input string text);
    while (!steady && $urandom_range(0, 99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, c, v};
    s_tuser  <= st;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    if (text.len() != 0) begin
      for (int i = 0; i < text.len(); i++)
        chars_due.push_back({CHAR_W'(text[i]), i == text.len() - 1});
    end else begin
      format_decimal(v, c, st);
    end
  endtask

  // Hold off the sender until every queued character is out.
  task automatic drain_pause();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (chars_due.size() != 0);
  endtask

  always @(posedge clk) begin : rx_side
    out_char_t due;
    if (rst) m_tready <= 1'b0;
    else m_tready <= steady || ($urandom_range(0, 99) >= 31);
    if (!rst && m_tvalid && m_tready) begin
      if (chars_due.size() == 0) begin
        report_mismatch("unexpected char", m_tdata, 0);
      end else begin
        due = chars_due.pop_front();
        if (m_tdata[6:0] != due.ch) report_mismatch("text_char", m_tdata[6:0], due.ch);
        if (m_tlast != due.last) report_mismatch("last_char", m_tlast, due.last);
        if (m_tdata[7] != 1'b0) report_mismatch("tdata pad", m_tdata[7], 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] v;
    logic [4:0]  c;
    logic [1:0]  st;
    int          pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r])
      send_request(dir_rows[r].value, dir_rows[r].count, dir_rows[r].style, dir_rows[r].text);
    drain_pause();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= 150 && n < 250);
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: v = $urandom;
        3, 4:    v = $urandom_range(0, 999);
        5:       v = 32'd0 - 32'($urandom_range(1, 1000));
        6: begin
          case ($urandom_range(0, 2))
            0:       v = 32'h8000_0000 + $urandom_range(0, 3);
            1:       v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
          endcase
        end
        7: begin
          // powers of ten and one below: carries through every digit
          v = 32'd1;
          repeat ($urandom_range(0, 9)) v = v * 10;
          v = v - $urandom_range(0, 1);
        end
        default: v = $urandom >> $urandom_range(0, 31);
      endcase
      pick = $urandom_range(0, 19);
      if (pick == 0) c = 5'($urandom_range(0, 31));
      else if (pick == 1) c = 5'(MAX_DIGITS);
      else c = 5'($urandom_range(1, MAX_DIGITS));
      st = 2'($urandom_range(0, 3));
      send_request(v, c, st, "");
      if (n == 300) drain_pause();
    end

    s_tvalid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
